@@ rtl/mfkw_pkg.sv @@
// Package for the keyed wait-list: word types, operation and status codes,
// and the control and status bundles between the top level and each queue.
// No dependencies.
package mfkw_pkg;

    localparam logic [2:0] OP_ENQ   = 3'd0;
    localparam logic [2:0] OP_DEQ   = 3'd1;
    localparam logic [2:0] OP_PEEK  = 3'd2;
    localparam logic [2:0] OP_REM   = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;
    localparam logic [2:0] OP_CLR   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SLOT  = 3'd1;
    localparam logic [2:0] ST_DUP       = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  slot;
        logic [63:0] key;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] key_out;
        logic [4:0]  count;
        logic        is_empty;
    } out_word_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic remove;
        logic clear;
    } q_ctl_t;

    typedef struct packed {
        logic found;
        logic empty;
        logic full;
    } q_stat_t;

endpackage

@@ rtl/mfkw_cell.sv @@
// One key cell of a queue row: holds a key, compares it against the
// incoming key and takes its neighbour's key on a shift.
// Depends on nothing.
module mfkw_cell #(
    parameter int KEY_BITS = 64
) (
    input  logic                aclk,
    input  logic                cap,
    input  logic [KEY_BITS-1:0] cmp_key,
    input  logic                load,
    input  logic                shift,
    input  logic [KEY_BITS-1:0] load_key,
    input  logic [KEY_BITS-1:0] next_key,
    output logic [KEY_BITS-1:0] key_q,
    output logic                hit_q
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    logic                hit_reg;
    logic                hit_next;

    always_comb begin
        key_next = key_reg;
        if (shift) begin
            key_next = next_key;
        end else if (load) begin
            key_next = load_key;
        end
        hit_next = cap ? (key_reg == cmp_key) : hit_reg;
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        hit_reg <= hit_next;
    end

    assign key_q = key_reg;
    assign hit_q = hit_reg;

endmodule

@@ rtl/mfkw_queue.sv @@
// One queue: a row of key cells with the head in cell 0, plus its count.
// Depends on mfkw_pkg and mfkw_cell.
module mfkw_queue
    import mfkw_pkg::*;
#(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 64,
    parameter int CNT_W    = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cap,
    input  logic [KEY_BITS-1:0] cmp_key,
    input  q_ctl_t              ctl,
    output q_stat_t             stat,
    output logic [CNT_W-1:0]    cnt_after,
    output logic [KEY_BITS-1:0] head_key
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [KEY_BITS-1:0] keys  [DEPTH];
    logic [DEPTH-1:0]    hits;
    logic [DEPTH-1:0]    live_hits;
    logic [DEPTH-1:0]    shifts;
    logic [DEPTH-1:0]    loads;
    logic [IDX_W-1:0]    pos;
    logic                found;
    logic                full;
    logic                empty;
    logic                push_ok;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [KEY_BITS-1:0] nbr_key;
        if (i == DEPTH - 1) begin : g_tail
            assign nbr_key = '0;
        end else begin : g_mid
            assign nbr_key = keys[i+1];
        end

        assign live_hits[i] = hits[i] && (cnt_reg > CNT_W'(i));
        assign shifts[i]    = ctl.pop || (ctl.remove && found && (IDX_W'(i) >= pos));
        assign loads[i]     = push_ok && (cnt_reg == CNT_W'(i));

        mfkw_cell #(
            .KEY_BITS(KEY_BITS)
        ) u_cell (
            .aclk    (aclk),
            .cap     (cap),
            .cmp_key (cmp_key),
            .load    (loads[i]),
            .shift   (shifts[i]),
            .load_key(cmp_key),
            .next_key(nbr_key),
            .key_q   (keys[i]),
            .hit_q   (hits[i])
        );
    end

    // Keys are unique within a queue, so at most one live hit: OR-encode it.
    always_comb begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (live_hits[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    assign found   = |live_hits;
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign push_ok = ctl.push && !found && !full;

    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.clear) begin
            cnt_next = '0;
        end else if (push_ok) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if ((ctl.pop && !empty) || (ctl.remove && found)) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign stat.found = found;
    assign stat.empty = empty;
    assign stat.full  = full;
    assign cnt_after  = cnt_next;
    assign head_key   = keys[0];

endmodule

@@ rtl/multi_fifo_keyed_waitlist.sv @@
// Keyed wait-list top level: several FIFO queues of keys with keyed removal.
// Depends on mfkw_pkg and mfkw_queue.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one request word
//   (op, slot, key). Result channel m_valid/m_ready/m_data returns exactly
//   one status word (status, key_out, count, is_empty) per request, in order.
//   Each queue is a row of key cells; on acceptance every cell compares its
//   key with the request key and registers the match flag. The following
//   cycle updates the addressed row (append, or shift towards the head to close
//   a gap) or clears the count of every queue, and loads the result register.
//   m_valid is set by the update state, together with the result register.
//   A new request is not taken until the compare and the update of the
//   cell rows are done; one request is in flight at a time.
//   The result register holds its word while m_ready is low; s_ready stays
//   low until that word is taken or is being taken.
//   Reset (aresetn low, synchronous) empties every queue and drops any
//   pending result; key cells keep their contents, which are never read
//   beyond a queue's count.
module multi_fifo_keyed_waitlist
    import mfkw_pkg::*;
#(
    parameter int NUM_SLOTS   = 5,
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic                state_reg;
    logic                state_next;
    in_word_t            req_reg;
    in_word_t            req_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_word_t           out_reg;
    out_word_t           out_next;
    logic                accept;
    logic [KEY_BITS-1:0] cmp_key;

    q_ctl_t              ctls     [NUM_SLOTS];
    q_stat_t             stats    [NUM_SLOTS];
    logic [CNT_W-1:0]    cnts     [NUM_SLOTS];
    logic [KEY_BITS-1:0] heads    [NUM_SLOTS];

    q_stat_t             sel_stat;
    logic [CNT_W-1:0]    sel_cnt;
    logic [KEY_BITS-1:0] sel_head;
    logic [CNT_W+4:0]    cnt_ext;
    logic                slot_ok;

    assign s_ready = (state_reg == S_IDLE) && (!out_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign slot_ok = (32'(req_reg.slot) < NUM_SLOTS);
    assign cmp_key = (state_reg == S_UPD) ? req_reg.key[KEY_BITS-1:0]
                                          : s_data.key[KEY_BITS-1:0];

    for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_queue
        logic hit_slot;
        assign hit_slot       = (state_reg == S_UPD) && slot_ok && (req_reg.slot == 3'(s));
        assign ctls[s].push   = hit_slot && (req_reg.op == OP_ENQ);
        assign ctls[s].pop    = hit_slot && (req_reg.op == OP_DEQ);
        assign ctls[s].remove = hit_slot && (req_reg.op == OP_REM);
        assign ctls[s].clear  = (state_reg == S_UPD) && (req_reg.op == OP_CLR);

        mfkw_queue #(
            .DEPTH   (QUEUE_DEPTH),
            .KEY_BITS(KEY_BITS),
            .CNT_W   (CNT_W)
        ) u_queue (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cap      (accept),
            .cmp_key  (cmp_key),
            .ctl      (ctls[s]),
            .stat     (stats[s]),
            .cnt_after(cnts[s]),
            .head_key (heads[s])
        );
    end

    always_comb begin
        sel_stat = '0;
        sel_cnt  = '0;
        sel_head = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (req_reg.slot == 3'(s)) begin
                sel_stat = stats[s];
                sel_cnt  = cnts[s];
                sel_head = heads[s];
            end
        end
    end

    assign cnt_ext = {5'b0, sel_cnt};

    always_comb begin
        out_next          = out_reg;
        out_next.status   = ST_OK;
        out_next.key_out  = '0;
        out_next.count    = cnt_ext[4:0];
        out_next.is_empty = (sel_cnt == '0);
        if (req_reg.op == OP_CLR) begin
            out_next.count    = '0;
            out_next.is_empty = 1'b1;
        end else if (!slot_ok) begin
            out_next.status   = ST_BAD_SLOT;
            out_next.count    = '0;
            out_next.is_empty = 1'b0;
        end else begin
            case (req_reg.op)
                OP_ENQ: begin
                    if (sel_stat.found) begin
                        out_next.status = ST_DUP;
                    end else if (sel_stat.full) begin
                        out_next.status = ST_FULL;
                    end
                end
                OP_DEQ, OP_PEEK: begin
                    if (sel_stat.empty) begin
                        out_next.status = ST_EMPTY;
                    end else begin
                        out_next.key_out[KEY_BITS-1:0] = sel_head;
                    end
                end
                OP_REM: begin
                    if (!sel_stat.found) begin
                        out_next.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    out_next.status = ST_OK;
                end
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next   = s_data;
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        if (state_reg == S_UPD) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ rtl/mfkw_checker.sv @@
// Port-level checks for the keyed wait-list, bound to the top level.
// Depends on mfkw_pkg and multi_fifo_keyed_waitlist.
module mfkw_checker
    import mfkw_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    logic in_acc;

    assign in_acc = s_valid && s_ready;

    a_ready_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || m_ready))
        else $error("s_ready high while a result word is stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("second word accepted while one is in flight");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc ##1 aresetn) |=> m_valid)
        else $error("result word missing two cycles after acceptance");

    a_bad_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.status == ST_BAD_SLOT)) |->
            ((m_data.count == 5'd0) && !m_data.is_empty && (m_data.key_out == 64'd0)))
        else $error("bad-slot result word carries non-zero fields");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result word changed");

endmodule

bind multi_fifo_keyed_waitlist mfkw_checker u_mfkw_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);

@@ tb/multi_fifo_keyed_waitlist_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for multi_fifo_keyed_waitlist: directed and random request words,
// a scoreboard class that predicts every status word, and random valid/ready idling.
// Depends on mfkw_pkg and the multi_fifo_keyed_waitlist RTL.
module multi_fifo_keyed_waitlist_tb;
    import mfkw_pkg::*;

    localparam int NUM_SLOTS   = 5;
    localparam int QUEUE_DEPTH = 16;
    localparam int KEY_BITS    = 64;
    localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

    localparam logic [2:0] OP_SPARE_LO = 3'd6;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 1850;
    localparam int PHASE_WORDS  = 150;
    localparam int CYCLE_LIMIT  = 400000;

    class waitlist_scoreboard;
        logic [63:0] cells [NUM_SLOTS][QUEUE_DEPTH];
        int          fill [NUM_SLOTS];
        out_word_t   expected_words [$];
        int          errors;

        function new();
            foreach (fill[i]) fill[i] = 0;
            errors = 0;
        endfunction

        function int locate(int q, logic [63:0] k);
            for (int i = 0; i < fill[q]; i++) begin
                if (cells[q][i] == k) return i;
            end
            return -1;
        endfunction

        function void close_gap(int q, int pos);
            for (int i = pos; i + 1 < fill[q]; i++) cells[q][i] = cells[q][i + 1];
            fill[q]--;
        endfunction

        function out_word_t service(in_word_t w);
            out_word_t   r;
            logic [63:0] k;
            int          q;
            int          pos;
            r = '0;
            k = w.key & KEY_MASK;
            if (w.op == OP_CLR) begin
                foreach (fill[i]) fill[i] = 0;
                r.status   = ST_OK;
                r.is_empty = 1'b1;
                return r;
            end
            if (w.slot >= NUM_SLOTS) begin
                r.status = ST_BAD_SLOT;
                return r;
            end
            q = w.slot;
            pos = locate(q, k);
            r.status = ST_OK;
            case (w.op)
                OP_ENQ: begin
                    if (pos >= 0) begin
                        r.status = ST_DUP;
                    end else if (fill[q] >= QUEUE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        cells[q][fill[q]] = k;
                        fill[q]++;
                    end
                end
                OP_DEQ, OP_PEEK: begin
                    if (fill[q] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.key_out = cells[q][0];
                        if (w.op == OP_DEQ) close_gap(q, 0);
                    end
                end
                OP_REM: begin
                    if (pos < 0) r.status = ST_NOT_FOUND;
                    else close_gap(q, pos);
                end
                default: begin
                end
            endcase
            r.count    = 5'(fill[q]);
            r.is_empty = (fill[q] == 0);
            return r;
        endfunction

        function void note_request(in_word_t w);
            expected_words.push_back(service(w));
        endfunction

        function void flag(string field, logic [63:0] want, logic [63:0] got);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.status !== want.status)
                flag("status", 64'(want.status), 64'(got.status));
            if (got.key_out !== want.key_out) flag("key_out", want.key_out, got.key_out);
            if (got.count !== want.count)
                flag("count", 64'(want.count), 64'(got.count));
            if (got.is_empty !== want.is_empty)
                flag("is_empty", 64'(want.is_empty), 64'(got.is_empty));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    waitlist_scoreboard sb;
    int cycle_count = 0;

    multi_fifo_keyed_waitlist #(
        .NUM_SLOTS   (NUM_SLOTS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // receiver: stall patterns, with long hold-offs while the sender keeps offering
    initial begin
        int rx_cycles;
        int hold_left;
        int mode;
        rx_cycles = 0;
        hold_left = 0;
        mode = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            rx_cycles++;
            if (rx_cycles == 3000 || rx_cycles == 9000) hold_left = 400;
            if (rx_cycles % 50 == 0) mode = $urandom_range(0, 3);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (rx_cycles % 4 != 3);
                endcase
            end
        end
    end

    task automatic send_word(input in_word_t w);
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(w);
        @(negedge aclk);
    endtask

    task automatic send_fields(input logic [2:0] op, input logic [2:0] slot,
                               input logic [63:0] key);
        in_word_t w;
        w.op   = op;
        w.slot = slot;
        w.key  = key;
        send_word(w);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
    endtask

    function automatic in_word_t pick_word(int mix);
        in_word_t w;
        int       roll;
        int       enq_pct;
        int       q;
        roll = $urandom_range(0, 99);
        enq_pct = (mix == 1) ? 80 : (mix == 2) ? 15 : 35;
        if ($urandom_range(0, 9) == 0) w.slot = 3'($urandom_range(0, 7));
        else w.slot = 3'($urandom_range(0, NUM_SLOTS - 1));
        if (roll < enq_pct) begin
            w.op = OP_ENQ;
        end else if (roll == 99 && mix != 1) begin
            w.op = OP_CLR;
        end else if (roll >= 96) begin
            w.op = ($urandom_range(0, 1) == 0) ? OP_SPARE_LO : OP_SPARE_HI;
        end else begin
            case ($urandom_range(0, 3))
                0: w.op = OP_DEQ;
                1: w.op = OP_PEEK;
                2: w.op = OP_REM;
                default: w.op = OP_QUERY;
            endcase
        end
        w.key = {$urandom, $urandom};
        q = w.slot;
        if (q < NUM_SLOTS && sb.fill[q] > 0 &&
            ((w.op == OP_ENQ && $urandom_range(0, 4) == 0) ||
             (w.op == OP_REM && $urandom_range(0, 9) < 7)))
            w.key = sb.cells[q][$urandom_range(0, sb.fill[q] - 1)];
        return w;
    endfunction

    initial begin
        int burst_left;
        sb = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        burst_left = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty queue handling
        send_fields(OP_QUERY, 3'd0, 64'd0);
        send_fields(OP_DEQ,   3'd0, 64'd0);
        send_fields(OP_PEEK,  3'd0, 64'd0);
        send_fields(OP_REM,   3'd0, 64'd0);
        // key extremes, duplicate refusal, head removal
        send_fields(OP_ENQ,   3'd0, 64'd0);
        send_fields(OP_ENQ,   3'd0, {64{1'b1}});
        send_fields(OP_ENQ,   3'd0, 64'd0);
        send_fields(OP_PEEK,  3'd0, 64'd0);
        send_fields(OP_ENQ,   3'd4, 64'ha5a5_5a5a_c3c3_3c3c);
        send_fields(OP_REM,   3'd0, 64'd0);
        send_fields(OP_REM,   3'd0, 64'd5);
        send_fields(OP_DEQ,   3'd0, 64'd0);
        // bad slots on enqueue, dequeue, peek, remove and query, and the spare codes
        send_fields(OP_ENQ,      3'd5, 64'd1);
        send_fields(OP_DEQ,      3'd6, 64'd0);
        send_fields(OP_PEEK,     3'd7, 64'd0);
        send_fields(OP_REM,      3'd5, 64'd1);
        send_fields(OP_QUERY,    3'd7, 64'd0);
        send_fields(OP_SPARE_LO, 3'd7, 64'd0);
        send_fields(OP_SPARE_LO, 3'd4, 64'd0);
        send_fields(OP_SPARE_HI, 3'd4, 64'd0);
        // remove from the middle
        send_fields(OP_ENQ,   3'd1, 64'd1);
        send_fields(OP_ENQ,   3'd1, 64'd2);
        send_fields(OP_ENQ,   3'd1, 64'd3);
        send_fields(OP_REM,   3'd1, 64'd2);
        send_fields(OP_DEQ,   3'd1, 64'd0);
        // clear ignores slot and key
        send_fields(OP_CLR,   3'd7, {$urandom, $urandom});
        send_fields(OP_QUERY, 3'd4, 64'd0);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (burst_left == 0) begin
                pause_sender(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            send_word(pick_word((i / PHASE_WORDS) % 3));
        end
        s_valid <= 1'b0;

        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
